@@ rtl/saf_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and word types for the sub-anagram filter.
// No dependencies; every other file imports this package.
package saf_pkg;

    // Letter alphabet: 'a' to 'z' and the hyphen.
    localparam int unsigned NUM_LETTERS = 27;
    localparam int unsigned LETTER_W    = 5;
    localparam int unsigned LENGTH_W    = 6;
    localparam int unsigned NUMBER_W    = 20;

    localparam logic [LETTER_W-1:0] LETTER_LIMIT = LETTER_W'(NUM_LETTERS);
    localparam logic [LENGTH_W-1:0] MAX_WORD_LEN = {LENGTH_W{1'b1}};

    // Function codes of an input word.
    localparam logic FUNC_POOL = 1'b0;
    localparam logic FUNC_WORD = 1'b1;

    // One result word.
    typedef struct packed {
        logic                matched;
        logic [LENGTH_W-1:0] word_length;
        logic [NUMBER_W-1:0] word_number;
    } t_result;

endpackage

@@ rtl/saf_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the sub-anagram filter: one pool or candidate letter per word.
// Depends on saf_pkg for the field widths.
interface saf_in_if import saf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [LETTER_W-1:0] letter_code;
    logic                last;

    modport source (output valid, output func, output letter_code, output last,
                    input ready);
    modport sink   (input valid, input func, input letter_code, input last,
                    output ready);
endinterface

@@ rtl/saf_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the sub-anagram filter: one result per candidate word.
// Depends on saf_pkg for the field widths.
interface saf_out_if import saf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                matched;
    logic [LENGTH_W-1:0] word_length;
    logic [NUMBER_W-1:0] word_number;

    modport source (output valid, output matched, output word_length,
                    output word_number, input ready);
    modport sink   (input valid, input matched, input word_length,
                    input word_number, output ready);
endinterface

@@ rtl/sub_anagram_filter.sv @@
`timescale 1ns / 1ps
// Sub-anagram filter: per-letter pool counts and per-word use counts in one
// synchronous memory. Depends on saf_pkg, saf_in_if and saf_out_if.
//
// Usage:
//   i_in carries letter words. func = 0 adds a letter to the pool; the first
//   pool letter after one marked last starts a fresh pool and restarts word
//   numbering. func = 1 streams candidate word letters; the letter marked
//   last closes the word and one result word appears on o_out with the match
//   flag, the saturated length and the word number.
//   Throughput is one letter per cycle while i_in.ready is high. A word's last
//   letter passes the count memory read, then the update and write back; its
//   result is then registered in a result slot that drives o_out. Back-to-back
//   letters of the same code are served by a write-to-read bypass around memory.
//   Three result slots follow the update stage. When the receiver stalls they
//   fill, and i_in.ready drops once results stored plus the letter in flight
//   leave no free slot; nothing is lost.
//   After reset the pool is empty, word numbering starts at zero and the
//   next pool letter starts a new pool. Whole-table clears happen at once
//   through per-entry valid bits, so no clearing pass is needed.
module sub_anagram_filter
    import saf_pkg::*;
#(
    parameter int unsigned MAX_LETTER_COPIES = 15,
    parameter int unsigned WORD_NUMBER_BITS  = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    saf_in_if.sink       i_in,
    saf_out_if.source    o_out
);

    localparam int unsigned CNT_W      = $clog2(MAX_LETTER_COPIES + 1);
    localparam int unsigned FIFO_DEPTH = 3;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LETTER_COPIES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W:0]   FIFO_FULL = (PTR_W + 1)'(FIFO_DEPTH);

    typedef struct packed {
        logic [CNT_W-1:0] pool;
        logic [CNT_W-1:0] used;
    } t_entry;

    // Count memory and its registered read port.
    t_entry r_mem [0:NUM_LETTERS-1];
    t_entry r_rd_data;

    // Update stage.
    logic                r_s1_valid;
    logic                r_s1_func;
    logic [LETTER_W-1:0] r_s1_code;
    logic                r_s1_last;

    // Bypass of the write made at the same edge as the pending read.
    logic                r_byp_valid;
    logic [LETTER_W-1:0] r_byp_code;
    t_entry              r_byp_data;

    // Block state.
    logic [NUM_LETTERS-1:0]      r_pool_valid, n_pool_valid;
    logic [NUM_LETTERS-1:0]      r_used_valid, n_used_valid;
    logic                        r_pool_restart, n_pool_restart;
    logic                        r_word_failed, n_word_failed;
    logic [LENGTH_W-1:0]         r_letters_seen, n_letters_seen;
    logic [WORD_NUMBER_BITS-1:0] r_word_counter, n_word_counter;

    // Result slots.
    t_result          r_fifo [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    logic    in_accept;
    logic    out_pop;
    logic    in_range;
    logic    mem_we;
    logic    res_push;
    t_entry  cur;
    t_entry  wr_entry;
    t_result res;

    // Accept while the slots can hold every result that may be in flight.
    assign i_in.ready = ((PTR_W + 1)'(r_count) + (PTR_W + 1)'(r_s1_valid)) < FIFO_FULL;
    assign in_accept  = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;

    // Memory read for the accepted letter, and the write back of the update.
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_in.letter_code < LETTER_LIMIT)) begin
            r_rd_data <= r_mem[i_in.letter_code];
        end
        if (mem_we) begin
            r_mem[r_s1_code] <= wr_entry;
        end
    end

    // Update-stage pipeline register and bypass tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_accept;
            r_byp_valid <= mem_we;
        end
        if (in_accept) begin
            r_s1_func <= i_in.func;
            r_s1_code <= i_in.letter_code;
            r_s1_last <= i_in.last;
        end
        r_byp_code <= r_s1_code;
        r_byp_data <= wr_entry;
    end

    // Read, modify and decide the write back for the letter in the update stage.
    always_comb begin
        t_entry raw;
        raw            = (r_byp_valid && (r_byp_code == r_s1_code)) ? r_byp_data : r_rd_data;
        in_range       = r_s1_code < LETTER_LIMIT;
        cur.pool       = (in_range && r_pool_valid[r_s1_code]) ? raw.pool : '0;
        cur.used       = (in_range && r_used_valid[r_s1_code]) ? raw.used : '0;
        wr_entry       = cur;
        mem_we         = 1'b0;
        res_push       = 1'b0;
        n_pool_valid   = r_pool_valid;
        n_used_valid   = r_used_valid;
        n_pool_restart = r_pool_restart;
        n_word_failed  = r_word_failed;
        n_letters_seen = r_letters_seen;
        n_word_counter = r_word_counter;
        res.matched     = !r_word_failed;
        res.word_length = r_letters_seen;
        res.word_number = NUMBER_W'(r_word_counter);

        if (r_s1_valid) begin
            unique case (r_s1_func)
                FUNC_POOL: begin
                    // A new pool empties both tables and restarts the word state.
                    if (r_pool_restart) begin
                        cur            = '0;
                        wr_entry       = '0;
                        n_pool_valid   = '0;
                        n_used_valid   = '0;
                        n_word_failed  = 1'b0;
                        n_letters_seen = '0;
                        n_word_counter = '0;
                    end
                    if (in_range) begin
                        if (cur.pool < MAX_CNT) begin
                            wr_entry.pool = cur.pool + 1'b1;
                        end
                        mem_we                  = 1'b1;
                        n_pool_valid[r_s1_code] = 1'b1;
                        n_used_valid[r_s1_code] = 1'b1;
                    end
                    n_pool_restart = r_s1_last;
                end
                FUNC_WORD: begin
                    if (r_letters_seen != MAX_WORD_LEN) begin
                        n_letters_seen = r_letters_seen + 1'b1;
                    end
                    // Take one unused copy of the letter, or fail the word.
                    if (!r_word_failed) begin
                        if (in_range && (cur.used < cur.pool)) begin
                            wr_entry.used           = cur.used + 1'b1;
                            mem_we                  = 1'b1;
                            n_pool_valid[r_s1_code] = 1'b1;
                            n_used_valid[r_s1_code] = 1'b1;
                        end else begin
                            n_word_failed = 1'b1;
                        end
                    end
                    // Close the word: report, then clear the per-word state.
                    if (r_s1_last) begin
                        res_push        = 1'b1;
                        res.matched     = !n_word_failed;
                        res.word_length = n_letters_seen;
                        n_word_counter  = r_word_counter + 1'b1;
                        n_used_valid    = '0;
                        n_word_failed   = 1'b0;
                        n_letters_seen  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_valid   <= '0;
            r_used_valid   <= '0;
            r_pool_restart <= 1'b1;
            r_word_failed  <= 1'b0;
            r_letters_seen <= '0;
            r_word_counter <= '0;
        end else begin
            r_pool_valid   <= n_pool_valid;
            r_used_valid   <= n_used_valid;
            r_pool_restart <= n_pool_restart;
            r_word_failed  <= n_word_failed;
            r_letters_seen <= n_letters_seen;
            r_word_counter <= n_word_counter;
        end
    end

    // Result slots: written by the update stage, drained by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (res_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PTR_W + 1)'(res_push) - (PTR_W + 1)'(out_pop);
        end
        if (res_push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign o_out.valid       = r_count != '0;
    assign o_out.matched     = r_fifo[r_rd_ptr].matched;
    assign o_out.word_length = r_fifo[r_rd_ptr].word_length;
    assign o_out.word_number = r_fifo[r_rd_ptr].word_number;

endmodule
